// ----- hw/rtl/sctwa_pkg.sv -----
// shared types and constants for the sized cache table with aging
// no dependencies
`default_nettype none
package sctwa_pkg;

  localparam int IDX_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_EVICT  = 2'd1;
  localparam logic [1:0] KIND_FINAL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER = 2'd1;

  localparam logic [11:0] LIMIT_RESET  = 12'd64;
  localparam logic [31:0] MARKER_RESET = 32'hFFFF_FFFF;

  // one table record; age is kept as the lookup counter value at last touch
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] bytes;
    logic [31:0] stamp;
  } rec_t;

  localparam rec_t REC_RESET = '{id: 32'hFFFF_FFFF, bytes: 32'd0, stamp: 32'd0};

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    rec_t             data;
  } wr_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sctwa_table.sv -----
// record memory with registered read and per-entry valid bits
// depends on sctwa_pkg
`default_nettype none
module sctwa_table #(
  parameter int ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sctwa_pkg::rd_req_t rd,
  input  wire sctwa_pkg::wr_req_t wr,
  output sctwa_pkg::rec_t         rdata
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  sctwa_pkg::rec_t mem [ENTRIES];
  sctwa_pkg::rec_t raw;
  logic [ENTRIES-1:0] vld;
  logic rvld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      raw <= mem[rd.addr[AW-1:0]];
    end
  end

  // entries never written read as their reset record
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr[AW-1:0]] <= 1'b1;
      end
      if (rd.en) begin
        rvld <= vld[rd.addr[AW-1:0]];
      end
    end
  end

  assign rdata = rvld ? raw : sctwa_pkg::REC_RESET;

endmodule
`default_nettype wire

// ----- hw/rtl/sized_cache_table_with_aging.sv -----
// Sized cache table with aging. Records (id, byte size, age) live in one
// single-port-read memory. Every command walks the memory one record per cycle,
// so the read port sets the rate. A lookup scans every record, then emits its
// result. A miss scans for the total, then for each eviction scans for a victim
// and reports it, then gives the final report; a scan that finds no victim goes
// on to the final report without an eviction report. A result held in the
// output register stalls the next result until it is taken. A new request is
// taken only when the previous one has left its last result in the output
// register. Ages are kept as a stamp of a lookup counter, so aging all records
// is one increment. Reset is immediate: valid bits stand in for a clearing pass.
// depends on sctwa_pkg, sctwa_table
`default_nettype none
module sized_cache_table_with_aging #(
  parameter int ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // request channel
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // item_id[31:0], new_size[63:32]
  input  wire logic         s_tuser,   // cmd
  // result channel
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata,   // success[0], entry_index[6:1], entry_slot[12:7],
                                       // entry_size[44:13], sum_before[76:45],
                                       // sum_after[108:77], zero fill
  output logic [1:0]        m_tuser,   // kind
  output logic              m_tlast,   // last
  // configuration write channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [sctwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam logic [sctwa_pkg::IDX_W-1:0] ENT = sctwa_pkg::IDX_W'(ENTRIES);
  localparam logic [sctwa_pkg::IDX_W-1:0] LAST_IDX = sctwa_pkg::IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    IDLE, LK_SCAN, LK_EMIT, TOT_SCAN, CHECK, EV_SCAN, EV_EMIT, FIN_EMIT
  } state_t;

  state_t st;

  // configuration
  logic [11:0] limit;
  logic [31:0] marker;

  // request and scan bookkeeping
  logic [31:0] id_r, nsize_r, gstamp;
  logic [sctwa_pkg::IDX_W-1:0] scnt, pidx;
  logic pv;

  // lookup results
  logic found;
  logic [sctwa_pkg::IDX_W-1:0] fidx;
  logic [31:0] fbytes, prefix;

  // miss bookkeeping
  logic [31:0] pre_total, after;
  logic has_free, fin_ok;
  logic [sctwa_pkg::IDX_W-1:0] ffree, nev;

  // victim search
  logic sel, vdone;
  logic [sctwa_pkg::IDX_W-1:0] vi;
  logic [31:0] vsize;

  // output register fields
  logic o_success;
  logic [sctwa_pkg::IDX_W-1:0] o_index, o_slot;
  logic [31:0] o_size, o_before, o_after;

  sctwa_pkg::rd_req_t rd;
  sctwa_pkg::wr_req_t wr;
  sctwa_pkg::rec_t    r;

  logic can_emit, out_load, scan_st, scan_end, r_free;
  logic [31:0] age, thresh, budget, fit_sum, before_n;

  sctwa_table #(.ENTRIES(ENTRIES)) u_table (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd),
    .wr    (wr),
    .rdata (r)
  );

  assign s_tready  = (st == IDLE);
  assign cfg_ready = 1'b1;
  assign can_emit  = !m_tvalid || m_tready;
  // output register takes a new result this cycle
  assign out_load  = can_emit && ((st == LK_EMIT) || (st == EV_EMIT && sel) ||
                                  (st == FIN_EMIT));
  assign scan_st   = (st == LK_SCAN) || (st == TOT_SCAN) || (st == EV_SCAN);
  assign scan_end  = pv && (pidx == LAST_IDX);
  assign r_free    = (r.id == marker);
  assign age       = gstamp - r.stamp;
  assign thresh    = {22'd0, limit[11:2]};
  assign budget    = {limit, 20'd0};
  assign fit_sum   = after + nsize_r;
  assign before_n  = pre_total + r.bytes;

  always_comb begin
    rd.en   = scan_st && (scnt < ENT);
    rd.addr = scnt;
  end

  // write-backs happen only outside the scans, so a read never races a write
  always_comb begin
    wr = '0;
    priority if (st == LK_EMIT && can_emit && found) begin
      wr.en   = 1'b1;
      wr.addr = fidx;
      wr.data = '{id: id_r, bytes: fbytes, stamp: gstamp};
    end else if (st == EV_EMIT && can_emit && sel) begin
      wr.en   = 1'b1;
      wr.addr = vi;
      wr.data = '{id: marker, bytes: 32'd0, stamp: gstamp};
    end else if (st == FIN_EMIT && can_emit && fin_ok) begin
      wr.en   = 1'b1;
      wr.addr = ffree;
      wr.data = '{id: id_r, bytes: nsize_r, stamp: gstamp};
    end else begin
      wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= IDLE;
      limit    <= sctwa_pkg::LIMIT_RESET;
      marker   <= sctwa_pkg::MARKER_RESET;
      gstamp   <= 32'd0;
      m_tvalid <= 1'b0;
      pv       <= 1'b0;
      scnt     <= '0;
      nev      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sctwa_pkg::CFG_LIMIT) begin
          limit <= cfg_data[11:0];
        end else if (cfg_index == sctwa_pkg::CFG_MARKER) begin
          marker <= cfg_data;
        end
      end

      if (m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end

      pv   <= rd.en;
      pidx <= scnt;
      if (rd.en) begin
        scnt <= scnt + 1'b1;
      end

      unique case (st)
        IDLE: begin
          if (s_tvalid) begin
            id_r    <= s_tdata[31:0];
            nsize_r <= s_tdata[63:32];
            scnt    <= '0;
            if (!s_tuser) begin
              gstamp <= gstamp + 32'd1;  // ages every record by one
              found  <= 1'b0;
              prefix <= 32'd0;
              st     <= LK_SCAN;
            end else begin
              pre_total <= 32'd0;
              has_free  <= 1'b0;
              nev       <= '0;
              st        <= TOT_SCAN;
            end
          end
        end

        LK_SCAN: begin
          if (pv && !found) begin
            if (r.id == id_r) begin
              found  <= 1'b1;
              fidx   <= pidx;
              fbytes <= r.bytes;
            end else begin
              prefix <= prefix + r.bytes;
            end
          end
          if (scan_end) begin
            st <= LK_EMIT;
          end
        end

        LK_EMIT: begin
          if (can_emit) begin
            m_tvalid  <= 1'b1;
            m_tuser   <= sctwa_pkg::KIND_LOOKUP;
            m_tlast   <= 1'b1;
            o_success <= found;
            o_index   <= found ? fidx : ENT;
            o_slot    <= found ? fidx : '0;
            o_size    <= found ? fbytes : 32'd0;
            o_before  <= prefix;
            o_after   <= 32'd0;
            st        <= IDLE;
          end
        end

        TOT_SCAN: begin
          if (pv) begin
            pre_total <= before_n;
            if (r_free && !has_free) begin
              has_free <= 1'b1;
              ffree    <= pidx;
            end
          end
          if (scan_end) begin
            after <= before_n;
            st    <= CHECK;
          end
        end

        CHECK: begin
          if ((fit_sum > budget) || !has_free) begin
            if (nev >= ENT) begin
              fin_ok <= 1'b0;
              st     <= FIN_EMIT;
            end else begin
              sel   <= 1'b0;
              vdone <= 1'b0;
              vsize <= 32'hFFFF_FFFF;
              scnt  <= '0;
              st    <= EV_SCAN;
            end
          end else begin
            fin_ok <= 1'b1;
            st     <= FIN_EMIT;
          end
        end

        // first aged record wins, else smallest, lowest index on ties
        EV_SCAN: begin
          if (pv && !vdone && !r_free) begin
            if (age > thresh) begin
              sel   <= 1'b1;
              vi    <= pidx;
              vsize <= r.bytes;
              vdone <= 1'b1;
            end else if (r.bytes < vsize) begin
              sel   <= 1'b1;
              vi    <= pidx;
              vsize <= r.bytes;
            end
          end
          if (scan_end) begin
            st <= EV_EMIT;
          end
        end

        EV_EMIT: begin
          if (!sel) begin
            fin_ok <= 1'b0;
            st     <= FIN_EMIT;
          end else if (can_emit) begin
            m_tvalid  <= 1'b1;
            m_tuser   <= sctwa_pkg::KIND_EVICT;
            m_tlast   <= 1'b0;
            o_success <= 1'b0;
            o_index   <= vi;
            o_slot    <= vi;
            o_size    <= vsize;
            o_before  <= 32'd0;
            o_after   <= 32'd0;
            after     <= after - vsize;
            has_free  <= 1'b1;
            if (!has_free || (vi < ffree)) begin
              ffree <= vi;
            end
            nev <= nev + 1'b1;
            st  <= CHECK;
          end
        end

        FIN_EMIT: begin
          if (can_emit) begin
            m_tvalid  <= 1'b1;
            m_tuser   <= sctwa_pkg::KIND_FINAL;
            m_tlast   <= 1'b1;
            o_success <= fin_ok;
            o_index   <= fin_ok ? ffree : '0;
            o_slot    <= '0;
            o_size    <= 32'd0;
            o_before  <= pre_total;
            o_after   <= after;
            st        <= IDLE;
          end
        end

        default: st <= IDLE;
      endcase
    end
  end

  assign m_tdata = {3'd0, o_after, o_before, o_size, o_slot, o_index, o_success};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_evict_bound: assert property (@(posedge clk) disable iff (rst)
    nev <= ENT)
    else $error("more evictions than entries");

  a_hit_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sctwa_pkg::KIND_LOOKUP) && m_tdata[0] |-> o_index < ENT)
    else $error("lookup hit with index out of range");

  a_evict_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sctwa_pkg::KIND_EVICT) |-> !m_tlast && (st != IDLE))
    else $error("eviction report ends a request");
`endif

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking bench for sized_cache_table_with_aging: lookups, misses with evictions
// and config changes are predicted in a local table copy and compared per field
// depends on sctwa_pkg and the block rtl
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREC = 16;
  localparam int CYCLE_LIMIT = 1200000;

  typedef enum logic {OP_LOOKUP = 1'b0, OP_MISS = 1'b1} op_t;

  // one result as it leaves the block
  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic        success;
    logic [5:0]  index;
    logic [5:0]  slot;
    logic [31:0] size;
    logic [31:0] sum_before;
    logic [31:0] after;
  } answer_t;

  // a request to send; has_want marks rows with typed-in answers
  typedef struct {
    op_t         op;
    logic [31:0] id;
    logic [31:0] nsize;
    bit          has_want;
    answer_t     want;
  } req_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;   // item_id[31:0], new_size[63:32]
  logic s_tuser = 1'b0;        // cmd
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [111:0] m_tdata;       // success, index, slot, size, before, after
  logic [1:0] m_tuser;         // kind
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sctwa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #6 clk = ~clk;

  sized_cache_table_with_aging #(.ENTRIES(NREC)) i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // shadow copy of the table and registers
  logic [31:0] tbl_id [NREC];
  logic [31:0] tbl_bytes [NREC];
  logic [31:0] tbl_age [NREC];
  logic [5:0]  tbl_slot [NREC];
  logic [11:0] lim_mb;
  logic [31:0] marker;

  answer_t pending_answers[$];
  req_row_t rows[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;   // forces the receiver to stall

  function automatic answer_t mk(logic [1:0] k, logic l, logic s, logic [5:0] ix,
                                 logic [5:0] sl, logic [31:0] sz, logic [31:0] b,
                                 logic [31:0] a);
    answer_t r;
    r.kind = k; r.last = l; r.success = s; r.index = ix; r.slot = sl;
    r.size = sz; r.sum_before = b; r.after = a;
    return r;
  endfunction

  function automatic void queue_answer(answer_t a);
    pending_answers.insert(pending_answers.size(), a);
  endfunction

  function automatic void add_row(op_t op, logic [31:0] id, logic [31:0] nsize,
                                  bit has_want, answer_t want);
    req_row_t row;
    row.op = op; row.id = id; row.nsize = nsize;
    row.has_want = has_want; row.want = want;
    rows.insert(rows.size(), row);
  endfunction

  function automatic void shadow_reset();
    lim_mb = sctwa_pkg::LIMIT_RESET;
    marker = sctwa_pkg::MARKER_RESET;
    for (int i = 0; i < NREC; i++) begin
      tbl_id[i] = 32'hFFFF_FFFF; tbl_bytes[i] = 0; tbl_age[i] = 0; tbl_slot[i] = 6'(i);
    end
  endfunction

  // computes the answers of one request and updates the shadow table
  function automatic void predict_table(op_t op, logic [31:0] id, logic [31:0] nsize);
    logic [31:0] acc, pre_total, after, budget, thresh, vsize;
    bit has_free, sel, done;
    int n, vi;
    acc = 0;
    if (op == OP_LOOKUP) begin
      for (int i = 0; i < NREC; i++) tbl_age[i] += 1;
      for (int i = 0; i < NREC; i++) begin
        if (tbl_id[i] == id) begin
          tbl_age[i] = 0;
          queue_answer(mk(sctwa_pkg::KIND_LOOKUP, 1'b1, 1'b1, 6'(i), tbl_slot[i],
                          tbl_bytes[i], acc, 32'd0));
          return;
        end
        acc += tbl_bytes[i];
      end
      queue_answer(mk(sctwa_pkg::KIND_LOOKUP, 1'b1, 1'b0, 6'(NREC), 6'd0, 32'd0,
                      acc, 32'd0));
      return;
    end
    pre_total = 0;
    for (int i = 0; i < NREC; i++) pre_total += tbl_bytes[i];
    after = pre_total;
    budget = {lim_mb, 20'd0};
    thresh = {22'd0, lim_mb[11:2]};
    has_free = 0;
    for (int i = 0; i < NREC; i++) if (tbl_id[i] == marker) has_free = 1;
    n = 0;
    while (after + nsize > budget || !has_free) begin
      sel = 0; vi = 0; vsize = 32'hFFFF_FFFF; done = 0;
      for (int i = 0; i < NREC && !done; i++) begin
        if (tbl_id[i] != marker) begin
          if (tbl_bytes[i] < vsize) begin
            sel = 1; vi = i; vsize = tbl_bytes[i];
          end
          // aged-out record wins outright
          if (tbl_age[i] > thresh) begin
            sel = 1; vi = i; vsize = tbl_bytes[i]; done = 1;
          end
        end
      end
      if (!sel || n >= NREC) begin
        queue_answer(mk(sctwa_pkg::KIND_FINAL, 1'b1, 1'b0, 6'd0, 6'd0, 32'd0,
                        pre_total, after));
        return;
      end
      queue_answer(mk(sctwa_pkg::KIND_EVICT, 1'b0, 1'b0, 6'(vi), tbl_slot[vi], vsize,
                      32'd0, 32'd0));
      n++;
      tbl_id[vi] = marker; tbl_bytes[vi] = 0; tbl_age[vi] = 0; tbl_slot[vi] = 6'(vi);
      after -= vsize;
      has_free = 1;
    end
    for (int i = 0; i < NREC; i++) begin
      if (tbl_id[i] == marker) begin
        tbl_id[i] = id; tbl_bytes[i] = nsize; tbl_age[i] = 0; tbl_slot[i] = 6'(i);
        queue_answer(mk(sctwa_pkg::KIND_FINAL, 1'b1, 1'b1, 6'(i), 6'd0, 32'd0,
                        pre_total, after));
        return;
      end
    end
    queue_answer(mk(sctwa_pkg::KIND_FINAL, 1'b1, 1'b0, 6'd0, 6'd0, 32'd0,
                    pre_total, after));
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stall, plus forced hold-off
  always @(posedge clk) begin
    int g;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        answer_t got, exp;
        got = mk(m_tuser, m_tlast, m_tdata[0], m_tdata[6:1], m_tdata[12:7],
                 m_tdata[44:13], m_tdata[76:45], m_tdata[108:77]);
        if (pending_answers.size() == 0) begin
          $error("unexpected result kind=%0d", got.kind);
          errors++;
        end else begin
          exp = pending_answers.pop_front();
          if (got.kind !== exp.kind) begin
            $error("kind exp %0d got %0d", exp.kind, got.kind); errors++; end
          if (got.last !== exp.last) begin
            $error("last exp %0d got %0d", exp.last, got.last); errors++; end
          if (got.success !== exp.success) begin
            $error("success exp %0d got %0d", exp.success, got.success); errors++; end
          if (got.index !== exp.index) begin
            $error("entry_index exp %0d got %0d", exp.index, got.index); errors++; end
          if (got.slot !== exp.slot) begin
            $error("entry_slot exp %0d got %0d", exp.slot, got.slot); errors++; end
          if (got.size !== exp.size) begin
            $error("entry_size exp %h got %h", exp.size, got.size); errors++; end
          if (got.sum_before !== exp.sum_before) begin
            $error("sum_before exp %h got %h", exp.sum_before, got.sum_before);
            errors++;
          end
          if (got.after !== exp.after) begin
            $error("sum_after exp %h got %h", exp.after, got.after); errors++; end
        end
      end
      g = $urandom_range(0, 99);
      m_tready <= !hold_off && (g < 70 || (g < 72 ? 1'b0 : m_tready));
    end
  end

  task automatic write_reg(logic [sctwa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sctwa_pkg::CFG_LIMIT) lim_mb = val[11:0];
    else marker = val;
  endtask

  // wait for every pending result, then let the block settle
  task automatic wait_idle();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4 * NREC + 20) @(posedge clk);
  endtask

  // sends one request; predicts on acceptance
  task automatic send_req(op_t op, logic [31:0] id, logic [31:0] nsize);
    s_tvalid <= 1'b1; s_tuser <= op; s_tdata <= {nsize, id};
    do @(posedge clk); while (!s_tready);
    predict_table(op, id, nsize);
  endtask

  task automatic send_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 23);       // small pool for hits
    if (r < 7) return marker;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 32'h0040_0000);
    if (r < 7) return $urandom_range(0, 32'h0200_0000);
    if (r < 8) return 32'hFFFF_FFFF;
    if (r < 9) return 0;
    return $urandom();
  endfunction

  initial begin
    shadow_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; answers typed in where obvious
    add_row(OP_LOOKUP, 32'h0000_0005, 32'd0, 1'b1,
            mk(sctwa_pkg::KIND_LOOKUP, 1'b1, 1'b0, 6'(NREC), 6'd0, 32'd0, 32'd0, 32'd0));
    add_row(OP_MISS, 32'h0000_0005, 32'h0010_0000, 1'b1,
            mk(sctwa_pkg::KIND_FINAL, 1'b1, 1'b1, 6'd0, 6'd0, 32'd0, 32'd0, 32'd0));
    add_row(OP_LOOKUP, 32'h0000_0005, 32'd0, 1'b1,
            mk(sctwa_pkg::KIND_LOOKUP, 1'b1, 1'b1, 6'd0, 6'd0, 32'h0010_0000,
               32'd0, 32'd0));
    add_row(OP_MISS, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0);   // size all ones
    add_row(OP_MISS, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '0);
    add_row(OP_MISS, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0);   // insert the marker
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b0, '0);         // lookup of marker
    for (int i = 0; i < 18; i++)
      add_row(OP_MISS, 32'h100 + i, 32'h0080_0000, 1'b0, '0);   // fill and evict
    foreach (rows[k]) begin
      send_req(rows[k].op, rows[k].id, rows[k].nsize);
      if (rows[k].has_want) begin
        // typed-in answer must agree with the predictor
        if (pending_answers[$] != rows[k].want) begin
          $error("table row %0d disagrees with predictor", k);
          errors++;
        end
      end
      send_gap();
    end
    s_tvalid <= 1'b0;
    wait_idle();

    // random phases over several register settings, extremes among them
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_reg(sctwa_pkg::CFG_LIMIT, 32'd0);
        1: write_reg(sctwa_pkg::CFG_LIMIT, 32'd4095);
        2: write_reg(sctwa_pkg::CFG_MARKER, 32'h0000_0000);
        3: write_reg(sctwa_pkg::CFG_LIMIT, 32'd8);
        4: write_reg(sctwa_pkg::CFG_MARKER, $urandom_range(0, 23));
        5: write_reg(sctwa_pkg::CFG_LIMIT, $urandom_range(1, 4095));
        default: write_reg(sctwa_pkg::CFG_MARKER, 32'hFFFF_FFFF);
      endcase
      for (int k = 0; k < 57; k++) begin
        // receiver holds off while sender keeps offering
        if (ph == 2 && k == 10) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (300) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        // sender waits for everything to drain once
        if (ph == 4 && k == 30) begin
          s_tvalid <= 1'b0;
          while (pending_answers.size() != 0) @(posedge clk);
        end
        send_req(op_t'($urandom_range(0, 1)), pick_id(), pick_size());
        send_gap();
      end
      s_tvalid <= 1'b0;
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/sctwa_pkg.sv
hw/rtl/sctwa_table.sv
hw/rtl/sized_cache_table_with_aging.sv
test/tb_top.sv
